// File: design/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

    // Fixed field widths of the ports.
    localparam int SIZE_W    = 13;
    localparam int POS_OUT_W = 21;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    // Screen size after reset, in whole pixels.
    localparam int DEFAULT_WIDTH  = 1920;
    localparam int DEFAULT_HEIGHT = 1080;
    localparam int ABS_MAX_RESET  = 32767;

    // Event commands.
    localparam logic [CMD_W-1:0] CMD_REL_X  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REL_Y  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ABS_X  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ABS_Y  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BUTTON = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_X_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_Y_MIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_MAX  = 3'd5;

    // Status of the serial scaling unit as seen by the control logic.
    typedef struct packed {
        logic busy;
        logic done;
    } scl_stat_t;

endpackage

`default_nettype wire

// File: design/ppt_scaler.sv
`default_nettype none

// Serial absolute scaler: quotient = min(diff * top / denom, top).
// The product is formed one multiplier bit per cycle (shift and add), then
// the quotient is formed one bit per cycle by restoring division.
module ppt_scaler #(
    parameter int SW    = 16,
    parameter int POS_W = 21
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [SW-1:0]     diff,
    input  wire logic [SW-1:0]     denom,
    input  wire logic [POS_W-1:0]  top,
    output ppt_pkg::scl_stat_t     stat,
    output logic      [POS_W-1:0]  quotient
);
    import ppt_pkg::*;

    localparam int NUM_W   = POS_W + SW;
    localparam int CNT_MAX = (SW > POS_W) ? SW : POS_W;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [SW-1:0]    rem_reg, rem_next;
    logic [SW-1:0]    denom_reg, denom_next;
    logic [POS_W-1:0] top_reg, top_next;

    logic [POS_W:0]   mul_sum;
    logic [SW:0]      trial;
    logic [SW:0]      trial_sub;
    logic             fits;
    logic [SW-1:0]    upper;
    logic [POS_W-1:0] q_low;

    // One multiplier bit per cycle: add top to the high half, shift right.
    assign mul_sum = {1'b0, acc_reg[NUM_W-1:SW]}
                   + (acc_reg[0] ? {1'b0, top_reg} : {(POS_W + 1){1'b0}});

    // One quotient bit per cycle: bring down the next dividend bit.
    assign trial     = {rem_reg, acc_reg[POS_W-1]};
    assign fits      = (trial >= {1'b0, denom_reg});
    assign trial_sub = trial - {1'b0, denom_reg};

    assign upper = acc_reg[NUM_W-1:POS_W];
    assign q_low = acc_reg[POS_W-1:0];

    // Saturate the quotient at the screen size.
    assign quotient  = (q_low > top_reg) ? top_reg : q_low;
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_FIN);

    // Sequencer for the multiply and divide passes.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        denom_next = denom_reg;
        top_next   = top_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    acc_next   = {{POS_W{1'b0}}, diff};
                    denom_next = denom;
                    top_next   = top;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                acc_next = {mul_sum, acc_reg[SW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SW - 1)) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                // A quotient that needs more than POS_W bits is above top.
                cnt_next = '0;
                if (upper >= denom_reg) begin
                    acc_next[POS_W-1:0] = '1;
                    state_next          = S_FIN;
                end else begin
                    rem_next   = upper;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_next            = fits ? trial_sub[SW-1:0] : trial[SW-1:0];
                acc_next[POS_W-1:0] = {acc_reg[POS_W-2:0], fits};
                cnt_next            = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(POS_W - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        denom_reg <= denom_next;
        top_reg   <= top_next;
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !stat.busy)
        else $error("scaler started while busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |=> !stat.done)
        else $error("scaler done held for more than one cycle");

    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < denom_reg))
        else $error("partial remainder not below divisor");

    a_quot_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> (quotient <= top_reg))
        else $error("quotient above screen size");

endmodule

`default_nettype wire

// File: design/pointer_position_tracker.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------------------
// event in  | s_valid / s_ready      | s_command, s_event_value, s_from_absolute_device
// result    | m_valid / m_ready      | m_cursor_x/y, m_button_down, m_press_x/y, m_status
// config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready (always high)
//
// A relative, button, ignored or unscaled absolute item goes from T_IDLE to T_DONE and
// back to T_IDLE before the next acceptance. A scaled absolute item passes through T_BUSY,
// where the scaler forms one multiplier bit, then one quotient bit per cycle; a product
// already past the screen size skips the division. A result waits in the output
// register while the next item is accepted; a stalled result holds the block only when
// the next result is ready to load. Synchronous reset.
`default_nettype none

module pointer_position_tracker #(
    parameter int FRACTION_BITS = 8,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic        [ppt_pkg::CMD_W-1:0]     s_command,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       s_event_value,
    input  wire logic                                 s_from_absolute_device,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic             [ppt_pkg::POS_OUT_W-1:0] m_cursor_x,
    output logic             [ppt_pkg::POS_OUT_W-1:0] m_cursor_y,
    output logic                                      m_button_down,
    output logic             [ppt_pkg::POS_OUT_W-1:0] m_press_x,
    output logic             [ppt_pkg::POS_OUT_W-1:0] m_press_y,
    output logic             [ppt_pkg::STAT_W-1:0]    m_status,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [ppt_pkg::ADDR_W-1:0]    paddr,
    input  wire logic        [ppt_pkg::DATA_W-1:0]    pwdata,
    output logic             [ppt_pkg::DATA_W-1:0]    prdata,
    output logic                                      pready
);
    import ppt_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int POS_W  = SIZE_W + FRACTION_BITS;
    localparam int WIDE_W = (SW > SIZE_W) ? SW : SIZE_W;
    localparam int REL_W  = FRACTION_BITS + WIDE_W + 2;

    localparam logic [POS_W-1:0] POS_X_RST =
        POS_W'((DEFAULT_WIDTH * (1 << FRACTION_BITS)) / 2);
    localparam logic [POS_W-1:0] POS_Y_RST =
        POS_W'((DEFAULT_HEIGHT * (1 << FRACTION_BITS)) / 2);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_DONE = 2'd2;

    // Configuration registers.
    logic        [SIZE_W-1:0] width_reg, height_reg;
    logic signed [SW-1:0]     x_min_reg, x_max_reg, y_min_reg, y_max_reg;

    // Tracker state.
    logic [1:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_x_reg, pos_x_next;
    logic [POS_W-1:0] pos_y_reg, pos_y_next;
    logic             held_reg, held_next;
    logic [POS_W-1:0] latch_x_reg, latch_x_next;
    logic [POS_W-1:0] latch_y_reg, latch_y_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic             axis_y_reg, axis_y_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic                  load_out;
    logic [POS_OUT_W-1:0]  out_x_reg, out_y_reg, out_px_reg, out_py_reg;
    logic                  out_held_reg;
    logic [STAT_W-1:0]     out_status_reg;

    logic                     wr_en;
    logic [REG_IDX_W-1:0]     wr_idx;

    logic                     axis_y;
    logic [POS_W-1:0]         sel_pos;
    logic [SIZE_W-1:0]        sel_size;
    logic [POS_W-1:0]         top_sel;
    logic signed [REL_W-1:0]  pos_ext, delta_ext, top_ext, rel_sum;
    logic [POS_W-1:0]         rel_res;
    logic signed [SW-1:0]     sel_lo, sel_hi;
    logic signed [SW:0]       denom_s, diff_s;
    logic                     denom_pos, diff_pos;

    logic                     scl_start;
    scl_stat_t                scl_stat;
    logic [POS_W-1:0]         scl_quot;

    // APB register port.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[ADDR_W-1:2];

    always_comb begin
        case (wr_idx)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_X_MIN:  prdata = DATA_W'(x_min_reg);
            REG_X_MAX:  prdata = DATA_W'(x_max_reg);
            REG_Y_MIN:  prdata = DATA_W'(y_min_reg);
            REG_Y_MAX:  prdata = DATA_W'(y_max_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(DEFAULT_WIDTH);
            height_reg <= SIZE_W'(DEFAULT_HEIGHT);
            x_min_reg  <= '0;
            x_max_reg  <= SW'(ABS_MAX_RESET);
            y_min_reg  <= '0;
            y_max_reg  <= SW'(ABS_MAX_RESET);
        end else if (wr_en) begin
            case (wr_idx)
                REG_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                REG_X_MIN:  x_min_reg  <= pwdata[SW-1:0];
                REG_X_MAX:  x_max_reg  <= pwdata[SW-1:0];
                REG_Y_MIN:  y_min_reg  <= pwdata[SW-1:0];
                REG_Y_MAX:  y_max_reg  <= pwdata[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Axis selection for the incoming item.
    assign axis_y   = (s_command == CMD_REL_Y) || (s_command == CMD_ABS_Y);
    assign sel_pos  = axis_y ? pos_y_reg : pos_x_reg;
    assign sel_size = axis_y ? height_reg : width_reg;
    assign sel_lo   = axis_y ? y_min_reg : x_min_reg;
    assign sel_hi   = axis_y ? y_max_reg : x_max_reg;
    assign top_sel  = POS_W'(sel_size) << FRACTION_BITS;

    // Relative move: add the delta in pixels, then clamp to the screen.
    assign pos_ext   = REL_W'(sel_pos);
    assign delta_ext = REL_W'(s_event_value) <<< FRACTION_BITS;
    assign top_ext   = REL_W'(top_sel);
    assign rel_sum   = pos_ext + delta_ext;

    always_comb begin
        if (rel_sum[REL_W-1]) begin
            rel_res = '0;
        end else if (rel_sum >= top_ext) begin
            if (sel_size == '0) begin
                rel_res = '0;
            end else begin
                rel_res = POS_W'(sel_size - 1'b1) << FRACTION_BITS;
            end
        end else begin
            rel_res = rel_sum[POS_W-1:0];
        end
    end

    // Absolute sample: range and offset from the axis minimum.
    assign denom_s   = $signed({sel_hi[SW-1], sel_hi}) - $signed({sel_lo[SW-1], sel_lo});
    assign diff_s    = $signed({s_event_value[SW-1], s_event_value})
                     - $signed({sel_lo[SW-1], sel_lo});
    assign denom_pos = !denom_s[SW] && (denom_s != '0);
    assign diff_pos  = !diff_s[SW] && (diff_s != '0);

    ppt_scaler #(
        .SW    (SW),
        .POS_W (POS_W)
    ) u_scaler (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scl_start),
        .diff     (diff_s[SW-1:0]),
        .denom    (denom_s[SW-1:0]),
        .top      (top_sel),
        .stat     (scl_stat),
        .quotient (scl_quot)
    );

    assign s_ready  = (state_reg == T_IDLE);
    assign load_out = (state_reg == T_DONE) && (!m_valid_reg || m_ready);

    // Item sequencing and state update.
    always_comb begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        held_next    = held_reg;
        latch_x_next = latch_x_reg;
        latch_y_next = latch_y_reg;
        status_next  = status_reg;
        axis_y_next  = axis_y_reg;
        m_valid_next = m_valid_reg && !m_ready;
        scl_start    = 1'b0;
        case (state_reg)
            T_IDLE: begin
                if (s_valid) begin
                    state_next  = T_DONE;
                    status_next = STAT_OK;
                    case (s_command)
                        CMD_REL_X: begin
                            pos_x_next = rel_res;
                        end
                        CMD_REL_Y: begin
                            pos_y_next = rel_res;
                        end
                        CMD_ABS_X, CMD_ABS_Y: begin
                            if (!s_from_absolute_device) begin
                                status_next = STAT_IGNORED;
                            end else if (!denom_pos) begin
                                status_next = STAT_RANGE;
                            end else if (!diff_pos) begin
                                if (axis_y) begin
                                    pos_y_next = '0;
                                end else begin
                                    pos_x_next = '0;
                                end
                            end else begin
                                scl_start   = 1'b1;
                                axis_y_next = axis_y;
                                state_next  = T_BUSY;
                            end
                        end
                        CMD_BUTTON: begin
                            held_next = (s_event_value != '0);
                            if (s_event_value != '0) begin
                                latch_x_next = pos_x_reg;
                                latch_y_next = pos_y_reg;
                            end
                        end
                        default: begin
                            status_next = STAT_IGNORED;
                        end
                    endcase
                end
            end
            T_BUSY: begin
                if (scl_stat.done) begin
                    if (axis_y_reg) begin
                        pos_y_next = scl_quot;
                    end else begin
                        pos_x_next = scl_quot;
                    end
                    state_next = T_DONE;
                end
            end
            T_DONE: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    state_next   = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            pos_x_reg   <= POS_X_RST;
            pos_y_reg   <= POS_Y_RST;
            held_reg    <= 1'b0;
            latch_x_reg <= '0;
            latch_y_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            held_reg    <= held_next;
            latch_x_reg <= latch_x_next;
            latch_y_reg <= latch_y_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg <= status_next;
        axis_y_reg <= axis_y_next;
    end

    // Result register, loaded when the previous result has been taken.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_x_reg      <= POS_OUT_W'(pos_x_reg);
            out_y_reg      <= POS_OUT_W'(pos_y_reg);
            out_px_reg     <= POS_OUT_W'(latch_x_reg);
            out_py_reg     <= POS_OUT_W'(latch_y_reg);
            out_held_reg   <= held_reg;
            out_status_reg <= status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cursor_x    = out_x_reg;
    assign m_cursor_y    = out_y_reg;
    assign m_press_x     = out_px_reg;
    assign m_press_y     = out_py_reg;
    assign m_button_down = out_held_reg;
    assign m_status      = out_status_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !scl_stat.busy)
        else $error("item accepted while the scaler is busy");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        scl_stat.done |-> (state_reg == T_BUSY))
        else $error("scaler finished outside of a scaled item");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_IGNORED
                     || m_status == STAT_RANGE))
        else $error("result carries an undefined status");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == T_DONE))
        else $error("result presented without a finished item");

endmodule

`default_nettype wire
